FILE: rtl/core/afl_pkg.sv
// Shared types, constants and the sequencer program of the audio format list builder.
package afl_pkg;

   localparam int MAX_SETTINGS_DEF = 8;
   localparam int MAX_RATES_DEF    = 16;
   localparam int MAX_OUT_DEF      = 64;

   localparam int LIMIT_W        = 7;
   localparam int RATE_W         = 32;
   localparam int PACKET_W       = 13;
   localparam int SAMPLES_W      = 13;
   localparam int CS_W           = 16;
   localparam int BYTES_W        = SAMPLES_W + CS_W;

   localparam logic [LIMIT_W-1:0] MAX_ENTRIES_RST = 7'd64;
   localparam logic [7:0]         NATIVE_SUBSLOT  = 8'd4;

   // 8000 microframes per second; a rate above 8000 * 8191 needs more samples per
   // microframe than any payload can hold, so the ceiling below only has to be exact
   // up to that bound.
   localparam logic [RATE_W-1:0] RATE_CAP    = 32'd65528000;
   localparam logic [25:0]       ROUND_UP    = 26'd7999;
   // floor(y / 125) = (y * RECIP_125) >> 28 for y below 2^20
   localparam logic [21:0]       RECIP_125   = 22'd2147484;
   localparam int                RECIP_SHIFT = 28;

   typedef enum logic [1:0] {
      CMD_CLEAR    = 2'd0,
      CMD_ADD_SET  = 2'd1,
      CMD_ADD_RATE = 2'd2,
      CMD_BUILD    = 2'd3
   } command_type;

   typedef struct packed {
      logic [7:0]          alt;
      logic [7:0]          channels;
      logic [7:0]          subslot;
      logic [7:0]          resolution;
      logic                raw;
      logic [PACKET_W-1:0] packet;
   } setting_type;

   localparam int SETTING_W = $bits(setting_type);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_INIT,
      ST_SET_RD,
      ST_SET_CHK,
      ST_RATE_RD,
      ST_MUL1,
      ST_MUL2,
      ST_TEST,
      ST_NEXT_SET,
      ST_PASS_END,
      ST_FLUSH
   } step_type;

   typedef enum logic [3:0] {
      CND_NEVER,
      CND_ALWAYS,
      CND_NO_BUILD,
      CND_SET_DONE,
      CND_WRONG_PASS,
      CND_RATE_DONE,
      CND_EMIT_BLOCKED,
      CND_PASS_ZERO,
      CND_OUT_BUSY
   } cond_type;

   typedef struct packed {
      logic no_build;
      logic set_done;
      logic wrong_pass;
      logic rate_done;
      logic emit_blocked;
      logic pass_zero;
      logic out_busy;
   } flags_type;

   typedef struct packed {
      step_type target;
      cond_type jump;
      cond_type hold;
      logic     init;
      logic     clr_rate;
      logic     inc_set;
      logic     inc_rate;
      logic     set_pass;
      logic     mul1;
      logic     mul2;
      logic     emit;
      logic     flush;
   } ucode_type;

   function automatic logic cond_eval(cond_type c, flags_type f);
      logic r;
      case (c)
         CND_NEVER:        r = 1'b0;
         CND_ALWAYS:       r = 1'b1;
         CND_NO_BUILD:     r = f.no_build;
         CND_SET_DONE:     r = f.set_done;
         CND_WRONG_PASS:   r = f.wrong_pass;
         CND_RATE_DONE:    r = f.rate_done;
         CND_EMIT_BLOCKED: r = f.emit_blocked;
         CND_PASS_ZERO:    r = f.pass_zero;
         CND_OUT_BUSY:     r = f.out_busy;
         default:          r = 1'b0;
      endcase
      return r;
   endfunction

   // Program ROM: one control word per step.
   function automatic ucode_type ucode(step_type s);
      ucode_type w;
      w = '0;
      w.target = ST_IDLE;
      case (s)
         ST_IDLE: begin
            w.hold = CND_NO_BUILD;
         end
         ST_INIT: begin
            w.init = 1'b1;
         end
         ST_SET_RD: begin
            w.jump   = CND_SET_DONE;
            w.target = ST_PASS_END;
         end
         ST_SET_CHK: begin
            w.clr_rate = 1'b1;
            w.jump     = CND_WRONG_PASS;
            w.target   = ST_NEXT_SET;
         end
         ST_RATE_RD: begin
            w.jump   = CND_RATE_DONE;
            w.target = ST_NEXT_SET;
         end
         ST_MUL1: begin
            w.mul1 = 1'b1;
         end
         ST_MUL2: begin
            w.mul2 = 1'b1;
         end
         ST_TEST: begin
            w.hold     = CND_EMIT_BLOCKED;
            w.emit     = 1'b1;
            w.inc_rate = 1'b1;
            w.jump     = CND_ALWAYS;
            w.target   = ST_RATE_RD;
         end
         ST_NEXT_SET: begin
            w.inc_set = 1'b1;
            w.jump    = CND_ALWAYS;
            w.target  = ST_SET_RD;
         end
         ST_PASS_END: begin
            w.set_pass = 1'b1;
            w.jump     = CND_PASS_ZERO;
            w.target   = ST_SET_RD;
         end
         ST_FLUSH: begin
            w.hold   = CND_OUT_BUSY;
            w.flush  = 1'b1;
            w.jump   = CND_ALWAYS;
            w.target = ST_IDLE;
         end
         default: begin
            w.jump   = CND_ALWAYS;
            w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

FILE: rtl/core/afl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module afl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/audio_format_list_builder.sv
// Audio format list builder: setting and rate tables walked by a microcoded sequencer.
//
// Input channel (req_*): one item is a command. Clear empties both tables, append
// setting / append rate add one table entry (dropped when the table is full), and
// build walks every setting and rate pair, non-native settings first, native second.
// Clear and append give no result. req_stall is high while a
// build runs.
// Result channel (rsp_*): a build gives one item per format entry that fits the
// setting's packet payload, up to min(max_entries, MAX_OUT); rsp_last marks the final
// one. A build with no entry gives one item with rsp_entry_valid low and rsp_last high.
// Each setting and rate pair takes four steps: the rate table read, the ceiling
// multiply, the byte-count multiply and the compare, all on one shared datapath;
// the remaining rates are skipped once the entry limit is hit. An entry is held
// back one slot so that the last one can be marked.
// When the receiver stalls, the walk stops at the next entry that needs the output
// register and resumes when the item is taken.
// csr_wr_en writes max_entries at any edge; write it only while no build runs.
// Reset empties both tables, sets max_entries to 64 and drops any pending result.
module audio_format_list_builder
   import afl_pkg::*;
#(
   parameter int MAX_SETTINGS = MAX_SETTINGS_DEF,
   parameter int MAX_RATES    = MAX_RATES_DEF,
   parameter int MAX_OUT      = MAX_OUT_DEF
) (
   input  logic                clock,
   input  logic                reset,

   input  logic                req_valid,
   output logic                req_stall,
   input  logic [1:0]          req_command,
   input  logic [7:0]          req_alt_number,
   input  logic [7:0]          req_channel_count,
   input  logic [7:0]          req_subslot_size,
   input  logic [7:0]          req_resolution_bits,
   input  logic                req_raw_flag,
   input  logic [PACKET_W-1:0] req_packet_bytes,
   input  logic [RATE_W-1:0]   req_rate_hz,

   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic                rsp_entry_valid,
   output logic [RATE_W-1:0]   rsp_entry_rate,
   output logic [7:0]          rsp_entry_alt,
   output logic [7:0]          rsp_entry_channels,
   output logic [7:0]          rsp_entry_resolution,
   output logic [7:0]          rsp_entry_subslot,
   output logic                rsp_native_flag,
   output logic                rsp_last,

   input  logic                csr_wr_en,
   input  logic [LIMIT_W-1:0]  csr_wr_data
);

   localparam int SCW  = $clog2(MAX_SETTINGS + 1);
   localparam int SAW  = (MAX_SETTINGS > 1) ? $clog2(MAX_SETTINGS) : 1;
   localparam int RCW  = $clog2(MAX_RATES + 1);
   localparam int RAW  = (MAX_RATES > 1) ? $clog2(MAX_RATES) : 1;
   localparam int OCW  = $clog2(MAX_OUT + 1);

   // control state
   step_type           pc_ff, pc_in;
   logic               pass_ff, pass_in;
   logic [SCW-1:0]     set_idx_ff, set_idx_in;
   logic [RCW-1:0]     rate_idx_ff, rate_idx_in;
   logic [SCW-1:0]     set_count_ff, set_count_in;
   logic [RCW-1:0]     rate_total_ff, rate_total_in;
   logic [OCW-1:0]     written_ff, written_in;
   logic               pend_v_ff, pend_v_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [LIMIT_W-1:0] max_entries_ff, max_entries_in;

   // datapath
   logic [SAMPLES_W-1:0] samples_ff;
   logic [CS_W-1:0]      cs_ff;
   logic                 reject_ff;
   logic [BYTES_W-1:0]   bytes_ff;
   logic [RATE_W-1:0]    pend_rate_ff;
   setting_type          pend_set_ff;
   logic                 pend_native_ff;

   logic                 rsp_entry_valid_ff;
   logic [RATE_W-1:0]    rsp_entry_rate_ff;
   logic [7:0]           rsp_entry_alt_ff;
   logic [7:0]           rsp_entry_channels_ff;
   logic [7:0]           rsp_entry_resolution_ff;
   logic [7:0]           rsp_entry_subslot_ff;
   logic                 rsp_native_flag_ff;
   logic                 rsp_last_ff;

   ucode_type          uw;
   flags_type          flags;
   logic               hold_now;
   logic               jump_now;
   logic               req_accept;
   logic               rsp_take;
   logic               out_busy;
   logic               set_we;
   logic               rate_we;
   logic [SETTING_W-1:0] set_wdata;
   logic [SETTING_W-1:0] set_rdata;
   logic [RATE_W-1:0]  rate_rdata;
   setting_type        set_rd;
   logic               native;
   logic               fit;
   logic [LIMIT_W-1:0] limit;
   logic               written_full;
   logic [25:0]        rate_rounded;
   logic [41:0]        recip_prod;
   logic               out_load;
   logic               out_src_pend;
   logic               out_last;
   logic               pend_load;

   assign req_stall  = (pc_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_take   = rsp_valid_ff && !rsp_stall;
   assign out_busy   = rsp_valid_ff && rsp_stall;

   assign set_we    = req_accept && (req_command == CMD_ADD_SET) &&
                      (set_count_ff < SCW'(MAX_SETTINGS));
   assign rate_we   = req_accept && (req_command == CMD_ADD_RATE) &&
                      (rate_total_ff < RCW'(MAX_RATES));
   assign set_wdata = {req_alt_number, req_channel_count, req_subslot_size,
                       req_resolution_bits, req_raw_flag, req_packet_bytes};

   afl_ram #(.WIDTH(SETTING_W), .DEPTH(MAX_SETTINGS)) u_set_ram (
      .clock   (clock),
      .wr_en   (set_we),
      .wr_addr (set_count_ff[SAW-1:0]),
      .wr_data (set_wdata),
      .rd_addr (set_idx_ff[SAW-1:0]),
      .rd_data (set_rdata)
   );

   afl_ram #(.WIDTH(RATE_W), .DEPTH(MAX_RATES)) u_rate_ram (
      .clock   (clock),
      .wr_en   (rate_we),
      .wr_addr (rate_total_ff[RAW-1:0]),
      .wr_data (req_rate_hz),
      .rd_addr (rate_idx_ff[RAW-1:0]),
      .rd_data (rate_rdata)
   );

   assign set_rd = setting_type'(set_rdata);
   assign native = set_rd.raw && (set_rd.subslot == NATIVE_SUBSLOT);

   assign limit = (max_entries_ff < LIMIT_W'(MAX_OUT)) ? max_entries_ff : LIMIT_W'(MAX_OUT);
   assign written_full = (LIMIT_W'(written_ff) >= limit);

   // ceil(rate / 8000) = floor(((rate + 7999) >> 6) / 125), valid below RATE_CAP
   assign rate_rounded = rate_rdata[25:0] + ROUND_UP;
   assign recip_prod   = 42'(rate_rounded[25:6]) * 42'(RECIP_125);

   assign fit = !reject_ff && (bytes_ff <= BYTES_W'(set_rd.packet));

   assign uw = ucode(pc_ff);

   always_comb begin
      flags.no_build     = !(req_accept && (req_command == CMD_BUILD));
      flags.set_done     = (set_idx_ff >= set_count_ff);
      flags.wrong_pass   = (native != pass_ff);
      flags.rate_done    = (rate_idx_ff >= rate_total_ff) || written_full;
      flags.emit_blocked = fit && pend_v_ff && out_busy;
      flags.pass_zero    = !pass_ff;
      flags.out_busy     = out_busy;
   end

   assign hold_now = cond_eval(uw.hold, flags);
   assign jump_now = cond_eval(uw.jump, flags);

   always_comb begin
      pc_in          = pc_ff;
      pass_in        = pass_ff;
      set_idx_in     = set_idx_ff;
      rate_idx_in    = rate_idx_ff;
      set_count_in   = set_count_ff;
      rate_total_in  = rate_total_ff;
      written_in     = written_ff;
      pend_v_in      = pend_v_ff;
      rsp_valid_in   = rsp_valid_ff;
      max_entries_in = max_entries_ff;
      out_load       = 1'b0;
      out_src_pend   = 1'b0;
      out_last       = 1'b0;
      pend_load      = 1'b0;

      if (csr_wr_en) begin
         max_entries_in = csr_wr_data;
      end

      if (req_accept && (req_command == CMD_CLEAR)) begin
         set_count_in  = '0;
         rate_total_in = '0;
      end
      if (set_we) begin
         set_count_in = set_count_ff + SCW'(1);
      end
      if (rate_we) begin
         rate_total_in = rate_total_ff + RCW'(1);
      end

      if (rsp_take) begin
         rsp_valid_in = 1'b0;
      end

      if (!hold_now) begin
         if (uw.init) begin
            pass_in    = 1'b0;
            set_idx_in = '0;
            written_in = '0;
            pend_v_in  = 1'b0;
         end
         if (uw.clr_rate) begin
            rate_idx_in = '0;
         end
         if (uw.inc_set) begin
            set_idx_in = set_idx_ff + SCW'(1);
         end
         if (uw.inc_rate) begin
            rate_idx_in = rate_idx_ff + RCW'(1);
         end
         if (uw.set_pass) begin
            pass_in    = 1'b1;
            set_idx_in = '0;
         end
         // hand the held entry on, then hold the new one
         if (uw.emit && fit) begin
            if (pend_v_ff) begin
               out_load     = 1'b1;
               out_src_pend = 1'b1;
               rsp_valid_in = 1'b1;
            end
            pend_load  = 1'b1;
            pend_v_in  = 1'b1;
            written_in = written_ff + OCW'(1);
         end
         if (uw.flush) begin
            out_load     = 1'b1;
            out_src_pend = pend_v_ff;
            out_last     = 1'b1;
            rsp_valid_in = 1'b1;
            pend_v_in    = 1'b0;
         end
      end

      if (hold_now) begin
         pc_in = pc_ff;
      end else if (jump_now) begin
         pc_in = uw.target;
      end else begin
         pc_in = step_type'(4'(pc_ff) + 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff          <= ST_IDLE;
         pass_ff        <= 1'b0;
         set_idx_ff     <= '0;
         rate_idx_ff    <= '0;
         set_count_ff   <= '0;
         rate_total_ff  <= '0;
         written_ff     <= '0;
         pend_v_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_entries_ff <= MAX_ENTRIES_RST;
      end else begin
         pc_ff          <= pc_in;
         pass_ff        <= pass_in;
         set_idx_ff     <= set_idx_in;
         rate_idx_ff    <= rate_idx_in;
         set_count_ff   <= set_count_in;
         rate_total_ff  <= rate_total_in;
         written_ff     <= written_in;
         pend_v_ff      <= pend_v_in;
         rsp_valid_ff   <= rsp_valid_in;
         max_entries_ff <= max_entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (uw.mul1) begin
         samples_ff <= recip_prod[RECIP_SHIFT +: SAMPLES_W];
         cs_ff      <= CS_W'(set_rd.channels) * CS_W'(set_rd.subslot);
         reject_ff  <= (rate_rdata > RATE_CAP) || (rate_rdata == '0) ||
                       (set_rd.channels == 8'd0) || (set_rd.subslot == 8'd0);
      end
      if (uw.mul2) begin
         bytes_ff <= BYTES_W'(samples_ff) * BYTES_W'(cs_ff);
      end
      if (pend_load) begin
         pend_rate_ff   <= rate_rdata;
         pend_set_ff    <= set_rd;
         pend_native_ff <= native;
      end
      if (out_load) begin
         rsp_entry_valid_ff      <= out_src_pend;
         rsp_entry_rate_ff       <= out_src_pend ? pend_rate_ff : '0;
         rsp_entry_alt_ff        <= out_src_pend ? pend_set_ff.alt : 8'd0;
         rsp_entry_channels_ff   <= out_src_pend ? pend_set_ff.channels : 8'd0;
         rsp_entry_resolution_ff <= out_src_pend ? pend_set_ff.resolution : 8'd0;
         rsp_entry_subslot_ff    <= out_src_pend ? pend_set_ff.subslot : 8'd0;
         rsp_native_flag_ff      <= out_src_pend && pend_native_ff;
         rsp_last_ff             <= out_last;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_entry_valid      = rsp_entry_valid_ff;
   assign rsp_entry_rate       = rsp_entry_rate_ff;
   assign rsp_entry_alt        = rsp_entry_alt_ff;
   assign rsp_entry_channels   = rsp_entry_channels_ff;
   assign rsp_entry_resolution = rsp_entry_resolution_ff;
   assign rsp_entry_subslot    = rsp_entry_subslot_ff;
   assign rsp_native_flag      = rsp_native_flag_ff;
   assign rsp_last             = rsp_last_ff;

   a_build_starts: assert property (@(posedge clock) disable iff (reset)
      req_accept && (req_command == CMD_BUILD) |=> pc_ff == ST_INIT)
      else $error("build item did not start the walk");

   a_written_bound: assert property (@(posedge clock) disable iff (reset)
      (pc_ff != ST_IDLE) && (pc_ff != ST_INIT) |-> LIMIT_W'(written_ff) <= limit)
      else $error("entry count passed the limit");

   a_pend_counted: assert property (@(posedge clock) disable iff (reset)
      pend_v_ff |-> written_ff != '0)
      else $error("held entry without a count");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      (pc_ff == ST_FLUSH) && !out_busy |=> rsp_valid_ff && rsp_last_ff && (pc_ff == ST_IDLE))
      else $error("flush did not present a last item");

   a_table_bound: assert property (@(posedge clock) disable iff (reset)
      (set_count_ff <= SCW'(MAX_SETTINGS)) && (rate_total_ff <= RCW'(MAX_RATES)))
      else $error("table count above depth");

endmodule
